// ----- hw/rtl/mtp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtp_pkg
// Shared types and constants for the match timer peripheral: item codes,
// register map, beat structs and the match compare result.
// ----------------------------------------------------------------------------
package mtp_pkg;

  // Number of match channels that take part in the compare (1 to 4)
  localparam int NUM_MATCH  = 4;
  // Match and capture registers always present in the map
  localparam int MATCH_REGS = 4;
  localparam int FLAG_W     = 4;

  // Item kinds; the fourth code does nothing
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // Register map, byte offsets
  localparam logic [9:0] ADDR_IR   = 10'h000;
  localparam logic [9:0] ADDR_TCR  = 10'h004;
  localparam logic [9:0] ADDR_TC   = 10'h008;
  localparam logic [9:0] ADDR_PR   = 10'h00C;
  localparam logic [9:0] ADDR_PC   = 10'h010;
  localparam logic [9:0] ADDR_MCR  = 10'h014;
  localparam logic [9:0] ADDR_MR0  = 10'h018;
  localparam logic [9:0] ADDR_MR1  = 10'h01C;
  localparam logic [9:0] ADDR_MR2  = 10'h020;
  localparam logic [9:0] ADDR_MR3  = 10'h024;
  localparam logic [9:0] ADDR_CCR  = 10'h028;
  localparam logic [9:0] ADDR_CR0  = 10'h02C;
  localparam logic [9:0] ADDR_CR1  = 10'h030;
  localparam logic [9:0] ADDR_CR2  = 10'h034;
  localparam logic [9:0] ADDR_CR3  = 10'h038;
  localparam logic [9:0] ADDR_EMR  = 10'h03C;
  localparam logic [9:0] ADDR_CTCR = 10'h070;

  // TCR bits
  localparam int TCR_EN  = 0;
  localparam int TCR_RST = 1;

  // External match actions
  localparam logic [1:0] EM_NONE   = 2'd0;
  localparam logic [1:0] EM_CLEAR  = 2'd1;
  localparam logic [1:0] EM_SET    = 2'd2;
  localparam logic [1:0] EM_TOGGLE = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  address;
    logic [31:0] write_data;
  } mtp_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_pulse;
    logic [3:0]  match_outputs;
  } mtp_out_t;

  // Outcome of one compare over all match channels
  typedef struct packed {
    logic [FLAG_W-1:0] set_flags;
    logic [31:0]       ext_match;
    logic              do_reset;
    logic              stop;
  } mtp_match_t;

endpackage

// ----- hw/rtl/mtp_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtp_match
// Compares the count with each match register and works out the interrupt
// flags, external match outputs, reset and stop requests in one pass.
// ----------------------------------------------------------------------------
module mtp_match
  import mtp_pkg::*;
(
  input  logic [31:0]                 count_i,
  input  logic [31:0]                 match_control_i,
  input  logic [MATCH_REGS-1:0][31:0] match_values_i,
  input  logic [31:0]                 ext_match_i,
  output mtp_match_t                  res_o
);

  // All channels see the same count; reset is applied by the caller
  always_comb begin
    logic [1:0] act;
    act   = EM_NONE;
    res_o = '{set_flags: '0, ext_match: ext_match_i, do_reset: 1'b0, stop: 1'b0};
    for (int i = 0; i < NUM_MATCH; i++) begin
      if (count_i == match_values_i[i]) begin
        if (match_control_i[3*i]) begin
          res_o.set_flags[i] = 1'b1;
        end
        act = ext_match_i[4+2*i +: 2];
        case (act)
          EM_CLEAR:  res_o.ext_match[i] = 1'b0;
          EM_SET:    res_o.ext_match[i] = 1'b1;
          EM_TOGGLE: res_o.ext_match[i] = ~ext_match_i[i];
          default:   ;
        endcase
        if (match_control_i[3*i+1]) begin
          res_o.do_reset = 1'b1;
        end
        if (match_control_i[3*i+2]) begin
          res_o.stop = 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/mtp_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtp_core
// Timer register file and the single-pass step: tick, bus read or bus write
// applied to the state, producing one result beat.
// ----------------------------------------------------------------------------
module mtp_core
  import mtp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  mtp_in_t  item_i,
  output mtp_out_t res_o
);

  logic [FLAG_W-1:0]           flags_q, flags_d;
  logic [FLAG_W-1:0]           raised_q, raised_d;
  logic [1:0]                  tcr_q, tcr_d;
  logic [31:0]                 tc_q, tc_d;
  logic [31:0]                 pr_q, pr_d;
  logic [31:0]                 pc_q, pc_d;
  logic [31:0]                 mcr_q, mcr_d;
  logic [MATCH_REGS-1:0][31:0] mr_q, mr_d;
  logic [31:0]                 emr_q, emr_d;
  logic [31:0]                 ccr_q, ccr_d;
  logic [MATCH_REGS-1:0][31:0] cr_q, cr_d;
  logic [3:0]                  ctcr_q, ctcr_d;

  logic        running;
  logic        cmp_en;
  logic [31:0] cmp_count;
  logic [31:0] tc_inc;
  logic [9:0]  mr_off;
  logic [9:0]  cr_off;
  mtp_match_t  match;

  assign running = tcr_q[TCR_EN] && !tcr_q[TCR_RST];
  assign tc_inc  = tc_q + 32'd1;
  assign mr_off  = item_i.address - ADDR_MR0;
  assign cr_off  = item_i.address - ADDR_CR0;

  // Compare source: incremented count on a tick, current count on enable
  always_comb begin
    cmp_en    = 1'b0;
    cmp_count = tc_q;
    if (item_i.kind == KIND_TICK && running && pc_q == pr_q) begin
      cmp_en    = 1'b1;
      cmp_count = tc_inc;
    end else if (item_i.kind == KIND_WRITE && item_i.address == ADDR_TCR &&
                 item_i.write_data[TCR_EN] && !item_i.write_data[TCR_RST] &&
                 (!tcr_q[TCR_EN] || tcr_q[TCR_RST])) begin
      cmp_en = 1'b1;
    end
  end

  mtp_match u_match (
    .count_i         (cmp_count),
    .match_control_i (mcr_q),
    .match_values_i  (mr_q),
    .ext_match_i     (emr_q),
    .res_o           (match)
  );

  // Next state and result
  always_comb begin
    logic             ann_en;
    logic [FLAG_W-1:0] ann_raised;
    flags_d    = flags_q;
    raised_d   = raised_q;
    tcr_d      = tcr_q;
    tc_d       = tc_q;
    pr_d       = pr_q;
    pc_d       = pc_q;
    mcr_d      = mcr_q;
    mr_d       = mr_q;
    emr_d      = emr_q;
    ccr_d      = ccr_q;
    cr_d       = cr_q;
    ctcr_d     = ctcr_q;
    ann_en     = 1'b0;
    ann_raised = raised_q;
    res_o      = '0;

    case (item_i.kind)
      KIND_TICK: begin
        if (running) begin
          if (pc_q == pr_q) begin
            pc_d = '0;
            tc_d = tc_inc;
          end else begin
            pc_d = pc_q + 32'd1;
          end
        end
      end
      KIND_READ: begin
        unique case (item_i.address)
          ADDR_IR:   res_o.read_data = {{(32-FLAG_W){1'b0}}, flags_q};
          ADDR_TCR:  res_o.read_data = {30'd0, tcr_q};
          ADDR_TC:   res_o.read_data = tcr_q[TCR_RST] ? 32'd0 : tc_q;
          ADDR_PR:   res_o.read_data = pr_q;
          ADDR_PC:   res_o.read_data = pc_q;
          ADDR_MCR:  res_o.read_data = mcr_q;
          ADDR_MR0, ADDR_MR1, ADDR_MR2, ADDR_MR3:
                     res_o.read_data = mr_q[mr_off[3:2]];
          ADDR_CCR:  res_o.read_data = ccr_q;
          ADDR_CR0, ADDR_CR1, ADDR_CR2, ADDR_CR3:
                     res_o.read_data = cr_q[cr_off[3:2]];
          ADDR_EMR:  res_o.read_data = emr_q;
          ADDR_CTCR: res_o.read_data = {28'd0, ctcr_q};
          default:   res_o.read_data = '0;
        endcase
      end
      KIND_WRITE: begin
        unique case (item_i.address)
          ADDR_IR: begin
            // write one to clear
            flags_d    = flags_q & ~item_i.write_data[FLAG_W-1:0];
            ann_en     = 1'b1;
            ann_raised = raised_q & flags_d;
          end
          ADDR_TCR: begin
            tcr_d = item_i.write_data[1:0];
            if (item_i.write_data[TCR_RST]) begin
              tc_d = '0;
              pc_d = '0;
            end
          end
          ADDR_TC:   tc_d = item_i.write_data;
          ADDR_PR:   pr_d = item_i.write_data;
          ADDR_PC:   pc_d = item_i.write_data;
          ADDR_MCR:  mcr_d = item_i.write_data;
          ADDR_MR0, ADDR_MR1, ADDR_MR2, ADDR_MR3:
                     mr_d[mr_off[3:2]] = item_i.write_data;
          ADDR_CCR:  ccr_d = item_i.write_data;
          ADDR_EMR:  emr_d = item_i.write_data;
          ADDR_CTCR: ctcr_d = item_i.write_data[3:0];
          default: begin
            // capture writes decode the whole window, not just word offsets
            if (item_i.address >= ADDR_CR0 && item_i.address <= ADDR_CR3) begin
              cr_d[cr_off[3:2]] = item_i.write_data;
            end
          end
        endcase
      end
      default: ;
    endcase

    // Apply the compare after the item's own update
    if (cmp_en) begin
      flags_d = flags_q | match.set_flags;
      emr_d   = match.ext_match;
      if (match.do_reset) begin
        tc_d = '0;
        pc_d = '0;
      end
      if (match.stop) begin
        tcr_d[TCR_EN] = 1'b0;
      end
      ann_en = 1'b1;
    end

    // A single pulse when any set flag has not been announced yet
    if (ann_en) begin
      raised_d = ann_raised;
      if ((flags_d & ~ann_raised) != '0) begin
        res_o.irq_pulse = 1'b1;
        raised_d        = flags_d;
      end
      if (flags_d == '0) begin
        raised_d = '0;
      end
    end

    res_o.match_outputs = emr_d[3:0];
  end

  // State registers, advanced once per processed beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q  <= '0;
      raised_q <= '0;
      tcr_q    <= '0;
      tc_q     <= '0;
      pr_q     <= '0;
      pc_q     <= '0;
      mcr_q    <= '0;
      mr_q     <= '0;
      emr_q    <= '0;
      ccr_q    <= '0;
      cr_q     <= '0;
      ctcr_q   <= '0;
    end else if (step_i) begin
      flags_q  <= flags_d;
      raised_q <= raised_d;
      tcr_q    <= tcr_d;
      tc_q     <= tc_d;
      pr_q     <= pr_d;
      pc_q     <= pc_d;
      mcr_q    <= mcr_d;
      mr_q     <= mr_d;
      emr_q    <= emr_d;
      ccr_q    <= ccr_d;
      cr_q     <= cr_d;
      ctcr_q   <= ctcr_d;
    end
  end

endmodule

// ----- hw/rtl/match_timer_peripheral.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// match_timer_peripheral
// Timer with prescaler and four match channels, driven by a stream of tick,
// read and write beats; one result beat per input beat.
// ----------------------------------------------------------------------------
// Path: input register, then the single-pass step into the result register.
// Throughput: one beat per cycle unless the result stalls; the step logic and
//   result register set it. A stalled result stalls the input only while the
//   input register is full.
// Reset: asynchronous, active low; all timer registers clear to zero.
module match_timer_peripheral
  import mtp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  mtp_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output mtp_out_t out_item_o
);

  logic     in_vld_q;
  mtp_in_t  in_q;
  logic     out_vld_q;
  mtp_out_t out_q;
  logic     step;
  mtp_out_t res;

  // Process the held beat whenever the result register is free or draining
  assign step       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !step;

  mtp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .res_o  (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  // A processed beat always lands in the result register
  a_step_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vld_q)
    else $error("processed beat did not reach the result register");

  // Reads never raise an interrupt pulse
  a_read_no_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_q.kind == KIND_READ) |=> !out_q.irq_pulse)
    else $error("interrupt pulse on a read beat");

  // Only reads return data
  a_nonread_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_q.kind != KIND_READ) |=> out_q.read_data == 32'd0)
    else $error("read data on a non-read beat");

endmodule
